// ===== src/fdf_pkg.sv =====
// Package: phase codes, register indexes, reset values and field widths for the fall detection block.
`default_nettype none

package fdf_pkg;

    // field widths
    localparam int ACCEL_W = 16;
    localparam int TILT_W  = 11;
    localparam int STAMP_W = 32;
    localparam int PHASE_W = 3;
    localparam int CFG_W   = 16;

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [2:0]         t_reg_idx;

    // phase codes
    localparam t_phase PH_IDLE      = 3'd0;
    localparam t_phase PH_FREEFALL  = 3'd1;
    localparam t_phase PH_IMPACT    = 3'd2;
    localparam t_phase PH_PREALERT  = 3'd3;
    localparam t_phase PH_WAITCONF  = 3'd4;
    localparam t_phase PH_CONFIRMED = 3'd5;

    // register indexes
    localparam t_reg_idx REG_FREEFALL_TH = 3'd0;
    localparam t_reg_idx REG_IMPACT_TH   = 3'd1;
    localparam t_reg_idx REG_ANGLE_TH    = 3'd2;
    localparam t_reg_idx REG_FF_WINDOW   = 3'd3;
    localparam t_reg_idx REG_PRE_ALERT   = 3'd4;
    localparam t_reg_idx REG_CONF_WAIT   = 3'd5;
    localparam t_reg_idx REG_STILL_CTR   = 3'd6;
    localparam t_reg_idx REG_STILL_BAND  = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_FREEFALL_TH = 16'd2048;
    localparam logic [CFG_W-1:0]  RST_IMPACT_TH   = 16'd10240;
    localparam logic [TILT_W-1:0] RST_ANGLE_TH    = 11'd600;
    localparam logic [CFG_W-1:0]  RST_FF_WINDOW   = 16'd500;
    localparam logic [CFG_W-1:0]  RST_PRE_ALERT   = 16'd5000;
    localparam logic [CFG_W-1:0]  RST_CONF_WAIT   = 16'd2000;
    localparam logic [CFG_W-1:0]  RST_STILL_CTR   = 16'd4096;
    localparam logic [CFG_W-1:0]  RST_STILL_BAND  = 16'd1229;

endpackage

`default_nettype wire

// ===== src/fdf_if.sv =====
// Interfaces: sample channel and result channel of the fall detection block.
`default_nettype none

interface fdf_in_if;
    logic                         valid;
    logic                         ready;
    logic [fdf_pkg::ACCEL_W-1:0]  accel_magnitude;
    logic [fdf_pkg::TILT_W-1:0]   tilt_angle;
    logic                         cancel_pressed;
    logic [fdf_pkg::STAMP_W-1:0]  now_ms;

    modport source (output valid, accel_magnitude, tilt_angle, cancel_pressed, now_ms,
                    input ready);
    modport sink   (input valid, accel_magnitude, tilt_angle, cancel_pressed, now_ms,
                    output ready);
endinterface

interface fdf_out_if;
    logic                         valid;
    logic                         ready;
    logic [fdf_pkg::PHASE_W-1:0]  fall_state;
    logic                         buzzer_pattern;
    logic                         emergency_pulse;

    modport source (output valid, fall_state, buzzer_pattern, emergency_pulse,
                    input ready);
    modport sink   (input valid, fall_state, buzzer_pattern, emergency_pulse,
                    output ready);
endinterface

`default_nettype wire

// ===== src/fall_detection_fsm.sv =====
// Top level: threshold fall detection state machine with APB register port.
//
//  channel   | dir | handshake     | word
//  ----------+-----+---------------+-----------------------------------------------
//  i_smp     | in  | valid/ready   | accel_magnitude, tilt_angle, cancel_pressed, now_ms
//  o_res     | out | valid/ready   | fall_state, buzzer_pattern, emergency_pulse
//  APB       | in  | psel/penable  | eight registers at byte address 4*i
//
//  One word per cycle while the result is not stalled; a result is offered once its
//  sample has passed the sample register and the state update into the result register.
//  While a result waits downstream the sample register takes one more word.
//  Synchronous active-low reset returns registers to defaults and phase to idle.
//  A stalled result holds; the input stalls only when both stages are full.
`default_nettype none

module fall_detection_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fdf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fdf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fdf_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    // streams
    fdf_in_if.sink                            i_smp,
    fdf_out_if.source                         o_res
);

    // configuration registers
    logic [fdf_pkg::CFG_W-1:0]  r_ff_th;
    logic [fdf_pkg::CFG_W-1:0]  r_imp_th;
    logic [fdf_pkg::TILT_W-1:0] r_ang_th;
    logic [fdf_pkg::CFG_W-1:0]  r_ff_win;
    logic [fdf_pkg::CFG_W-1:0]  r_pre_ms;
    logic [fdf_pkg::CFG_W-1:0]  r_conf_ms;
    logic [fdf_pkg::CFG_W-1:0]  r_ctr;
    logic [fdf_pkg::CFG_W-1:0]  r_band;

    fdf_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_th   <= fdf_pkg::RST_FREEFALL_TH;
            r_imp_th  <= fdf_pkg::RST_IMPACT_TH;
            r_ang_th  <= fdf_pkg::RST_ANGLE_TH;
            r_ff_win  <= fdf_pkg::RST_FF_WINDOW;
            r_pre_ms  <= fdf_pkg::RST_PRE_ALERT;
            r_conf_ms <= fdf_pkg::RST_CONF_WAIT;
            r_ctr     <= fdf_pkg::RST_STILL_CTR;
            r_band    <= fdf_pkg::RST_STILL_BAND;
        end else if (w_wr) begin
            case (w_idx)
                fdf_pkg::REG_FREEFALL_TH: r_ff_th   <= pwdata[15:0];
                fdf_pkg::REG_IMPACT_TH:   r_imp_th  <= pwdata[15:0];
                fdf_pkg::REG_ANGLE_TH:    r_ang_th  <= pwdata[10:0];
                fdf_pkg::REG_FF_WINDOW:   r_ff_win  <= pwdata[15:0];
                fdf_pkg::REG_PRE_ALERT:   r_pre_ms  <= pwdata[15:0];
                fdf_pkg::REG_CONF_WAIT:   r_conf_ms <= pwdata[15:0];
                fdf_pkg::REG_STILL_CTR:   r_ctr     <= pwdata[15:0];
                fdf_pkg::REG_STILL_BAND:  r_band    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_idx)
            fdf_pkg::REG_FREEFALL_TH: prdata = {16'd0, r_ff_th};
            fdf_pkg::REG_IMPACT_TH:   prdata = {16'd0, r_imp_th};
            fdf_pkg::REG_ANGLE_TH:    prdata = {21'd0, r_ang_th};
            fdf_pkg::REG_FF_WINDOW:   prdata = {16'd0, r_ff_win};
            fdf_pkg::REG_PRE_ALERT:   prdata = {16'd0, r_pre_ms};
            fdf_pkg::REG_CONF_WAIT:   prdata = {16'd0, r_conf_ms};
            fdf_pkg::REG_STILL_CTR:   prdata = {16'd0, r_ctr};
            fdf_pkg::REG_STILL_BAND:  prdata = {16'd0, r_band};
            default:                  prdata = '0;
        endcase
    end

    // pipeline control: sample register feeds the result register
    logic r_in_vld;
    logic r_out_vld;
    logic w_adv;
    logic w_step;

    assign w_adv       = !r_out_vld || o_res.ready;
    assign w_step      = r_in_vld && w_adv;
    assign i_smp.ready = !r_in_vld || w_adv;

    // sample register
    logic [fdf_pkg::ACCEL_W-1:0] r_accel;
    logic [fdf_pkg::TILT_W-1:0]  r_tilt;
    logic                        r_cancel;
    logic [fdf_pkg::STAMP_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_accel  <= i_smp.accel_magnitude;
            r_tilt   <= i_smp.tilt_angle;
            r_cancel <= i_smp.cancel_pressed;
            r_now    <= i_smp.now_ms;
        end
    end

    // timestamp cut or widened to the timer width
    logic [TIME_WIDTH-1:0] w_now;

    generate
        if (TIME_WIDTH <= fdf_pkg::STAMP_W) begin : g_cut
            assign w_now = r_now[TIME_WIDTH-1:0];
        end else begin : g_ext
            assign w_now = {{(TIME_WIDTH-fdf_pkg::STAMP_W){1'b0}}, r_now};
        end
    endgenerate

    // state
    fdf_pkg::t_phase       r_phase;
    fdf_pkg::t_phase       n_phase;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TIME_WIDTH-1:0] n_start;
    logic                  r_pat;
    logic                  n_pat;
    logic                  n_pulse;

    // elapsed time and stillness
    logic [TIME_WIDTH-1:0]       w_elapsed;
    logic [fdf_pkg::ACCEL_W-1:0] w_dev;
    logic                        w_still;

    assign w_elapsed = w_now - r_start;
    assign w_dev     = (r_accel >= r_ctr) ? (r_accel - r_ctr) : (r_ctr - r_accel);
    assign w_still   = w_dev < r_band;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_pat   = r_pat;
        n_pulse = 1'b0;
        case (r_phase)
            fdf_pkg::PH_IDLE: begin
                if (r_accel < r_ff_th) begin
                    n_phase = fdf_pkg::PH_FREEFALL;
                    n_start = w_now;
                end
            end
            fdf_pkg::PH_FREEFALL: begin
                // impact test has priority over the window timeout
                if (r_accel > r_imp_th) begin
                    n_phase = fdf_pkg::PH_IMPACT;
                end else if (w_elapsed > TIME_WIDTH'(r_ff_win)) begin
                    n_phase = fdf_pkg::PH_IDLE;
                end
            end
            fdf_pkg::PH_IMPACT: begin
                if (r_tilt > r_ang_th) begin
                    n_phase = fdf_pkg::PH_PREALERT;
                    n_start = w_now;
                    n_pat   = 1'b1;
                end else begin
                    n_phase = fdf_pkg::PH_IDLE;
                end
            end
            fdf_pkg::PH_PREALERT: begin
                // cancel wins over timeout
                if (r_cancel) begin
                    n_phase = fdf_pkg::PH_IDLE;
                    n_pat   = 1'b0;
                end else if (w_elapsed > TIME_WIDTH'(r_pre_ms)) begin
                    n_phase = fdf_pkg::PH_WAITCONF;
                    n_start = w_now;
                end
            end
            fdf_pkg::PH_WAITCONF: begin
                if (w_elapsed > TIME_WIDTH'(r_conf_ms)) begin
                    if (w_still) begin
                        n_phase = fdf_pkg::PH_CONFIRMED;
                        n_pulse = 1'b1;
                    end else begin
                        n_phase = fdf_pkg::PH_IDLE;
                    end
                end
            end
            fdf_pkg::PH_CONFIRMED: begin
                // holds until reset
            end
            default: begin
                n_phase = fdf_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fdf_pkg::PH_IDLE;
            r_start <= '0;
            r_pat   <= 1'b0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_pat   <= n_pat;
        end
    end

    // result register
    logic                 r_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_pulse <= n_pulse;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.fall_state      = r_phase;
    assign o_res.buzzer_pattern  = r_pat;
    assign o_res.emergency_pulse = r_pulse;

endmodule

`default_nettype wire

// ===== src/fdf_checker.sv =====
// Checker: port-level assertions for the fall detection block, bound to the top level.
`default_nettype none

module fdf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        i_ready,
    input wire logic [fdf_pkg::PHASE_W-1:0] i_state,
    input wire logic                        i_buzzer,
    input wire logic                        i_pulse
);

    // set once a confirmed result has been delivered
    logic r_seen_conf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_conf <= 1'b0;
        end else if (i_valid && i_ready && (i_state == fdf_pkg::PH_CONFIRMED)) begin
            r_seen_conf <= 1'b1;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_state) && $stable(i_buzzer)
                                && $stable(i_pulse))
        else $error("result changed while stalled");

    // the emergency pulse comes only with the confirmed state
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_pulse |-> i_state == fdf_pkg::PH_CONFIRMED)
        else $error("emergency pulse outside confirmed");

    // confirmed sticks and pulses only once
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_seen_conf |-> i_state == fdf_pkg::PH_CONFIRMED && !i_pulse)
        else $error("confirmed state left or pulse repeated");

    // buzzer is on throughout pre-alert
    a_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_state == fdf_pkg::PH_PREALERT |-> i_buzzer)
        else $error("buzzer off during pre-alert");

endmodule

bind fall_detection_fsm fdf_checker u_fdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_state  (o_res.fall_state),
    .i_buzzer (o_res.buzzer_pattern),
    .i_pulse  (o_res.emergency_pulse)
);

`default_nettype wire
